[rtl/core/sabs_pkg.sv]
// Shared constants and types for the sorted array bound search block.
package sabs_pkg;

  localparam int unsigned Depth   = 1024;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned CountW  = $clog2(Depth + 1);
  localparam int unsigned IndexW  = 11;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned OpW     = 2;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef logic [CountW-1:0] count_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [ValueW-1:0] value_t;

  // Bound kind register values.
  localparam logic BoundLower = 1'b0;
  localparam logic BoundUpper = 1'b1;

endpackage

[rtl/core/sabs_store.sv]
// Element store: single write port, single registered read port.
module sabs_store (
  input  logic            clk_i,
  input  logic            we_i,
  input  sabs_pkg::addr_t  waddr_i,
  input  sabs_pkg::value_t wdata_i,
  input  logic            re_i,
  input  sabs_pkg::addr_t  raddr_i,
  output sabs_pkg::value_t rdata_o
);

  sabs_pkg::value_t mem_q [sabs_pkg::Depth];
  sabs_pkg::value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sorted_array_bound_search.sv]
// Top level of the sorted array bound search block.
// The block holds up to 1024 signed 32-bit entries in a single-port-read
// memory, appended in order and emptied by a clear item. A query item runs a
// binary search with the midpoint rounded down and returns the lower bound
// (first entry >= target) or upper bound (first entry > target) as bound_kind
// selects, or the entry count if none qualifies. Items are handled one at a
// time: an append, clear or unknown item goes from acceptance straight to
// ST_DONE; a query runs one ST_PROBE and one ST_CMP per probe (at most 11 for
// a full store), with the memory read issued in ST_PROBE and the compare and
// bound update made in ST_CMP, and then goes to ST_DONE. A finished result
// waits in the output register, so the next item is taken while it is
// stalled. The store itself is not cleared after reset; only the count is.
module sorted_array_bound_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sabs_pkg::OpW-1:0]    in_operation_i,
  input  logic signed [sabs_pkg::ValueW-1:0] in_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sabs_pkg::IndexW-1:0] out_index_o,
  output logic                        out_status_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  sabs_pkg::count_t count_q, count_d;
  logic bound_kind_q;
  logic out_valid_q, out_valid_d;

  sabs_pkg::count_t lo_q, lo_d, hi_q, hi_d, found_q, found_d, mid_q, mid_d;
  sabs_pkg::value_t key_q, key_d;
  logic [sabs_pkg::IndexW-1:0] res_index_q, res_index_d, out_index_q;
  logic res_status_q, res_status_d, out_status_q;
  logic out_load;

  logic [sabs_pkg::CountW:0] mid_sum;
  sabs_pkg::count_t mid;
  logic accept, mem_we, mem_re, hit;
  sabs_pkg::value_t rdata;

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - {{sabs_pkg::CountW{1'b0}}, 1'b1};
  assign mid     = mid_sum[sabs_pkg::CountW:1];

  always_comb begin
    if (bound_kind_q == sabs_pkg::BoundUpper) begin
      hit = $signed(rdata) > $signed(key_q);
    end else begin
      hit = $signed(rdata) >= $signed(key_q);
    end
  end

  sabs_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[sabs_pkg::AddrW-1:0]),
    .wdata_i (in_value_i),
    .re_i    (mem_re),
    .raddr_i (mid[sabs_pkg::AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Writes happen only on acceptance and reads only later in the search, so
  // the two ports never touch the same entry in one cycle.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    found_d      = found_q;
    mid_d        = mid_q;
    key_d        = key_q;
    res_index_d  = res_index_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_status_d = 1'b0;
          res_index_d  = sabs_pkg::IndexW'(count_q);
          state_d      = ST_DONE;
          case (in_operation_i)
            sabs_pkg::OP_APPEND: begin
              if (count_q < sabs_pkg::CountW'(sabs_pkg::Depth)) begin
                mem_we      = 1'b1;
                count_d     = count_q + 1'b1;
                res_index_d = sabs_pkg::IndexW'(count_q + 1'b1);
              end else begin
                res_status_d = 1'b1;
              end
            end
            sabs_pkg::OP_QUERY: begin
              lo_d    = '0;
              hi_d    = count_q;
              found_d = count_q;
              key_d   = in_value_i;
              state_d = ST_PROBE;
            end
            sabs_pkg::OP_CLEAR: begin
              count_d     = '0;
              res_index_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PROBE: begin
        if (lo_q < hi_q) begin
          mem_re  = 1'b1;
          mid_d   = mid;
          state_d = ST_CMP;
        end else begin
          res_index_d  = sabs_pkg::IndexW'(found_q);
          res_status_d = 1'b0;
          state_d      = ST_DONE;
        end
      end
      ST_CMP: begin
        if (hit) begin
          found_d = mid_q;
          hi_d    = mid_q;
        end else begin
          lo_d = mid_q + 1'b1;
        end
        state_d = ST_PROBE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      bound_kind_q <= sabs_pkg::BoundLower;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        bound_kind_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    found_q      <= found_d;
    mid_q        <= mid_d;
    key_q        <= key_d;
    res_index_q  <= res_index_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_index_q  <= res_index_q;
      out_status_q <= res_status_q;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_status_o = out_status_q;

endmodule

[rtl/core/sabs_checker.sv]
// Port-level checks for the sorted array bound search block, with its bind.
module sabs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [sabs_pkg::IndexW-1:0] out_index_o,
  input logic                        out_status_o
);

  // A result never points past the end of a full store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_index_o <= sabs_pkg::IndexW'(sabs_pkg::Depth))
    else $error("result index beyond store depth");

  // A dropped append only happens with the store full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o) |-> out_index_o == sabs_pkg::IndexW'(sabs_pkg::Depth))
    else $error("drop flagged with store not full");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item taken while the first is in progress");

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_index_o) && $stable(out_status_o)))
    else $error("stalled result changed");

endmodule

bind sorted_array_bound_search sabs_checker u_sabs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_index_o  (out_index_o),
  .out_status_o (out_status_o)
);

[bench/tb_sorted_array_bound_search.sv]
// Self-checking testbench for the sorted array bound search block.
`timescale 1ns / 1ps

module tb_sorted_array_bound_search;

  localparam logic [sabs_pkg::OpW-1:0] OpUnknown = 2'd3;
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFull = 1'b1;
  localparam logic signed [sabs_pkg::ValueW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [sabs_pkg::ValueW-1:0] ValMax = 32'sh7fff_ffff;
  localparam longint ValMaxL    = 64'sd2147483647;
  localparam int     HoldCycles = 200;
  localparam int     CycleLimit = 400_000;

  typedef struct packed {
    logic [sabs_pkg::IndexW-1:0] index;
    logic                        status;
  } result_t;

  typedef struct {
    logic [sabs_pkg::OpW-1:0]              op;
    logic signed [sabs_pkg::ValueW-1:0]    val;
    bit                                    known;
    logic [sabs_pkg::IndexW-1:0]           index;
    logic                                  status;
  } dir_row_t;

  // Rows with known set carry the result that can be read off directly.
  dir_row_t directed_rows [22] = '{
    '{sabs_pkg::OP_QUERY,  -32'sd5,      1'b1, 11'd0, StatusOk},
    '{sabs_pkg::OP_APPEND, ValMin,       1'b1, 11'd1, StatusOk},
    '{sabs_pkg::OP_APPEND, -32'sd1,      1'b1, 11'd2, StatusOk},
    '{sabs_pkg::OP_APPEND, 32'sd0,       1'b1, 11'd3, StatusOk},
    '{sabs_pkg::OP_APPEND, 32'sd7,       1'b1, 11'd4, StatusOk},
    '{sabs_pkg::OP_APPEND, 32'sd7,       1'b1, 11'd5, StatusOk},
    '{sabs_pkg::OP_APPEND, ValMax,       1'b1, 11'd6, StatusOk},
    '{sabs_pkg::OP_QUERY,  ValMin,       1'b0, 11'd0, StatusOk},
    '{sabs_pkg::OP_QUERY,  32'sd7,       1'b0, 11'd0, StatusOk},
    '{sabs_pkg::OP_QUERY,  ValMax,       1'b0, 11'd0, StatusOk},
    '{sabs_pkg::OP_QUERY,  32'sd8,       1'b0, 11'd0, StatusOk},
    '{sabs_pkg::OP_QUERY,  -32'sd2,      1'b0, 11'd0, StatusOk},
    '{OpUnknown,           32'sd123,     1'b1, 11'd6, StatusOk},
    '{sabs_pkg::OP_CLEAR,  -32'sd1,      1'b1, 11'd0, StatusOk},
    '{sabs_pkg::OP_QUERY,  32'sd0,       1'b1, 11'd0, StatusOk},
    '{sabs_pkg::OP_APPEND, 32'sd5,       1'b1, 11'd1, StatusOk},
    '{sabs_pkg::OP_APPEND, -32'sd3,      1'b1, 11'd2, StatusOk},
    '{sabs_pkg::OP_APPEND, 32'sd9,       1'b1, 11'd3, StatusOk},
    '{sabs_pkg::OP_APPEND, 32'sd1,       1'b1, 11'd4, StatusOk},
    '{sabs_pkg::OP_QUERY,  32'sd2,       1'b0, 11'd0, StatusOk},
    '{sabs_pkg::OP_QUERY,  -32'sd3,      1'b0, 11'd0, StatusOk},
    '{sabs_pkg::OP_CLEAR,  ValMax,       1'b1, 11'd0, StatusOk}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [sabs_pkg::OpW-1:0] in_op = '0;
  logic signed [sabs_pkg::ValueW-1:0] in_val = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [sabs_pkg::IndexW-1:0] out_index;
  logic out_status;

  // Typed expectation travelling with the item being offered.
  bit                          tag_known = 1'b0;
  logic [sabs_pkg::IndexW-1:0] tag_index = '0;
  logic                        tag_status = 1'b0;

  // Predictor state.
  logic signed [sabs_pkg::ValueW-1:0] shadow_vals [sabs_pkg::Depth];
  sabs_pkg::count_t                   shadow_count = '0;
  logic                               shadow_upper = sabs_pkg::BoundLower;

  result_t pending_results [$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      items_sent = 0;
  int      send_gap_pct = 23;
  int      recv_stall_pct = 68;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  longint  run_value = 0;

  sorted_array_bound_search u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_operation_i (in_op),
    .in_value_i     (in_val),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_index_o    (out_index),
    .out_status_o   (out_status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic result_t compute_bound_result(
      logic [sabs_pkg::OpW-1:0] op, logic signed [sabs_pkg::ValueW-1:0] val);
    result_t res;
    int      lo;
    int      hi;
    int      mid;
    bit      hit;
    res.index  = shadow_count;
    res.status = StatusOk;
    case (op)
      sabs_pkg::OP_APPEND: begin
        if (shadow_count < sabs_pkg::Depth) begin
          shadow_vals[shadow_count[sabs_pkg::AddrW-1:0]] = val;
          shadow_count++;
          res.index = shadow_count;
        end else begin
          res.status = StatusFull;
        end
      end
      sabs_pkg::OP_QUERY: begin
        lo = 0;
        hi = int'(shadow_count) - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          hit = shadow_upper ? (shadow_vals[mid] > val) : (shadow_vals[mid] >= val);
          if (hit) begin
            res.index = mid[sabs_pkg::IndexW-1:0];
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
      sabs_pkg::OP_CLEAR: begin
        shadow_count = '0;
        res.index = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("MISMATCH cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
    error_count++;
  endtask

  // Results are checked before the newly accepted item is predicted; a result
  // can never belong to an item accepted on the same edge.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, index", -1, out_index);
        end else begin
          want = pending_results.pop_front();
          if (out_index !== want.index) report_mismatch("index", want.index, out_index);
          if (out_status !== want.status) report_mismatch("status", want.status, out_status);
        end
      end
      if (in_valid && !in_stall) begin
        got = compute_bound_result(in_op, in_val);
        if (tag_known) got = '{index: tag_index, status: tag_status};
        pending_results.push_back(got);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic [sabs_pkg::OpW-1:0] op,
                           logic signed [sabs_pkg::ValueW-1:0] val,
                           bit known = 1'b0, logic [sabs_pkg::IndexW-1:0] idx = '0,
                           logic stat = StatusOk);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_val     <= val;
    tag_known  <= known;
    tag_index  <= idx;
    tag_status <= stat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_bound_kind(logic upper);
    cfg_we    <= 1'b1;
    cfg_wdata <= upper;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_upper = upper;
  endtask

  function automatic logic signed [sabs_pkg::ValueW-1:0] pick_target();
    logic signed [sabs_pkg::ValueW-1:0] held;
    held = (shadow_count != 0) ? shadow_vals[$urandom_range(int'(shadow_count) - 1)]
                               : $urandom;
    case ($urandom_range(9))
      0: return ValMin;
      1: return ValMax;
      2, 3, 4, 5: return held;
      6: return held + 1;
      7: return held - 1;
      default: return $urandom;
    endcase
  endfunction

  // Appends an ascending run with frequent duplicates, saturating at the top.
  task automatic append_run(int count);
    repeat (count) begin
      send_item(sabs_pkg::OP_APPEND, run_value[sabs_pkg::ValueW-1:0]);
      if ($urandom_range(7) == 0) run_value += $urandom_range(1 << 20);
      else run_value += $urandom_range(3);
      if (run_value > ValMaxL) run_value = ValMaxL;
    end
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 10) begin
        // Noise: any operation code with any value, which may unsort the store.
        send_item(sabs_pkg::OpW'($urandom_range(3)), $urandom);
      end else begin
        if ($urandom_range(3) != 0 || shadow_count > 200) begin
          send_item(sabs_pkg::OP_CLEAR, $urandom);
          case ($urandom_range(3))
            0: run_value = longint'(ValMin);
            1: run_value = longint'(int'($urandom));
            2: run_value = longint'($urandom_range(200)) - 100;
            default: run_value = ValMaxL - $urandom_range(20);
          endcase
        end
        append_run(($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(10));
        repeat ($urandom_range(8, 1)) send_item(sabs_pkg::OP_QUERY, pick_target());
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_bound_kind(sabs_pkg::BoundLower);
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].val, directed_rows[i].known,
                directed_rows[i].index, directed_rows[i].status);
    wait_results_done();

    // The receiver holds off while items keep coming, so the block backs up.
    write_bound_kind(sabs_pkg::BoundUpper);
    hold_req = 1'b1;
    run_random(100);
    wait_results_done();

    // Fill the store completely; the last appends are dropped as full.
    send_gap_pct = 68;
    recv_stall_pct = 23;
    write_bound_kind(sabs_pkg::BoundLower);
    send_item(sabs_pkg::OP_CLEAR, '0);
    run_value = longint'(ValMin);
    append_run(sabs_pkg::Depth + 3);
    repeat (20) send_item(sabs_pkg::OP_QUERY, pick_target());
    wait_results_done();
    write_bound_kind(sabs_pkg::BoundUpper);
    repeat (20) send_item(sabs_pkg::OP_QUERY, pick_target());
    run_random(50);
    wait_results_done();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_bound_kind(sabs_pkg::BoundLower);
    run_random(50);
    wait_results_done();

    repeat (30) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/sabs_pkg.sv
rtl/core/sabs_store.sv
rtl/core/sorted_array_bound_search.sv
rtl/core/sabs_checker.sv
bench/tb_sorted_array_bound_search.sv
